// ===== rtl/ddo_pkg.sv =====
// shared constants, tables and helpers for the differential drive odometry block
package ddo_pkg;

    // input command codes (tuser)
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // configuration register indexes
    localparam logic REG_RADIUS = 1'b0;
    localparam logic REG_BINV   = 1'b1;

    localparam logic [15:0] RADIUS_RESET = 16'd1049;
    localparam logic [15:0] BINV_RESET   = 16'd3657;

    // datapath word of the shared multiplier and the rotator
    localparam int DW = 34;
    typedef logic signed [DW-1:0] t_word;

    localparam int TABLE_LEN = 24;

    localparam t_word CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam t_word INV_TWO_PI_Q32  = 34'sd683565276;
    localparam t_word TWO_PI_Q30      = 34'sd6746518852;

    // quarter turn in 2^-24 turn units
    localparam logic signed [23:0] QUARTER_TURN = 24'sh400000;

    // arctangent of 2^-i in Q30 radians
    function automatic t_word atan_q30(input logic [4:0] idx);
        t_word v;
        unique case (idx)
            5'd0:    v = 34'sh03243F6A8;
            5'd1:    v = 34'sh01DAC6705;
            5'd2:    v = 34'sh00FADBAFC;
            5'd3:    v = 34'sh007F56EA6;
            5'd4:    v = 34'sh003FEAB76;
            5'd5:    v = 34'sh001FFD55B;
            5'd6:    v = 34'sh000FFFAAA;
            5'd7:    v = 34'sh0007FFF55;
            5'd8:    v = 34'sh0003FFFEA;
            5'd9:    v = 34'sh0001FFFFD;
            5'd10:   v = 34'sh0000FFFFF;
            5'd11:   v = 34'sh00007FFFF;
            5'd12:   v = 34'sh00003FFFF;
            5'd13:   v = 34'sh00001FFFF;
            5'd14:   v = 34'sh00000FFFF;
            5'd15:   v = 34'sh000007FFF;
            5'd16:   v = 34'sh000003FFF;
            5'd17:   v = 34'sh000001FFF;
            5'd18:   v = 34'sh000000FFF;
            5'd19:   v = 34'sh0000007FF;
            5'd20:   v = 34'sh0000003FF;
            5'd21:   v = 34'sh0000001FF;
            5'd22:   v = 34'sh0000000FF;
            5'd23:   v = 34'sh00000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] sat_16(input logic signed [24:0] v);
        logic signed [15:0] r;
        if (v > 25'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -25'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat_32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -34'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/ddo_cordic.sv =====
// rotation-mode cordic, one micro-rotation per cycle
module ddo_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  ddo_pkg::t_word i_z,
    output logic           o_done,
    output ddo_pkg::t_word o_x,
    output ddo_pkg::t_word o_y
);

    localparam int CntW = $clog2(CORDIC_STEPS);
    localparam logic [CntW-1:0] Last = CntW'(CORDIC_STEPS - 1);

    ddo_pkg::t_word r_x, r_y, r_z;
    logic [CntW-1:0] r_i;
    logic            r_busy;
    logic            r_done;

    ddo_pkg::t_word xs, ys, ang;

    always_comb begin
        xs  = r_x >>> r_i;
        ys  = r_y >>> r_i;
        ang = ddo_pkg::atan_q30(5'(r_i));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= ddo_pkg::CORDIC_GAIN_Q30;
                r_y    <= '0;
                r_z    <= i_z;
                r_i    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // rotate toward zero residual angle
                if (!r_z[ddo_pkg::DW-1]) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - ang;
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + ang;
                end
                r_i <= r_i + 1'b1;
                if (r_i == Last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("cordic started while busy");

    a_done_clears_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("cordic done while still busy");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_i <= Last))
        else $error("cordic step counter out of range");

endmodule

// ===== rtl/differential_drive_odometry_unit.sv =====
// differential drive odometry: pose tracker with a shared multiplier and cordic
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready         tuser: command; tdata: left, right, tick_length
//  m_axis    out  tvalid/tready         tdata: x, y, heading, linear_speed, turn_rate
//  cfg       in   i_cfg_we              i_cfg_index, i_cfg_data
//
// a moving tick runs the cordic loop plus nine products through the one shared
// multiplier between accept and the next accept
// a clear command or a zero tick length runs the speed products only
// the result sits in an output register, so a stalled m_axis holds only the last
// item; the next item is taken and worked on meanwhile, and waits at the end
// synchronous active-low reset restores pose, stored speeds and both registers
module differential_drive_odometry_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [15:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,   // left_wheel_speed, right_wheel_speed, tick_length
    input  logic         s_axis_tuser,   // command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata    // pose_x, pose_y, heading, linear_speed, turn_rate
);

    typedef enum logic [3:0] {
        S_IDLE, S_MV, S_MW1, S_MW2, S_MP, S_MD, S_MA, S_MZ,
        S_CST, S_CORD, S_MX, S_MY, S_MH, S_FIN
    } t_state;

    t_state r_state;

    logic [15:0] r_radius, r_binv;

    // architectural state
    logic signed [31:0] r_pos_x, r_pos_y;
    logic [15:0]        r_heading;
    logic signed [15:0] r_left, r_right;

    // per-item work registers
    logic [15:0]        r_tick;
    logic               r_upd;
    logic signed [32:0] r_vfull;
    logic signed [24:0] r_wrate;
    logic [24:0]        r_d;
    logic [23:0]        r_a;
    logic               r_neg;
    logic signed [29:0] r_dist;
    logic signed [67:0] r_prod;

    // output register
    logic               r_out_valid;
    logic [111:0]       r_out_data;

    ddo_pkg::t_word mul_a, mul_b;
    ddo_pkg::t_word cord_x, cord_y, cos_v, sin_v;
    logic           cord_done;
    logic           cord_start;

    logic signed [16:0] spd_sum, spd_diff;
    logic [23:0]        mid;
    logic               mid_neg;
    logic [24:0]        d_rnd;
    logic signed [33:0] sum_x, sum_y;
    logic               in_acc;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign cord_start    = (r_state == S_CST);

    ddo_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_z     (34'($signed(r_prod[57:24]))),
        .o_done  (cord_done),
        .o_x     (cord_x),
        .o_y     (cord_y)
    );

    always_comb begin
        spd_sum  = 17'(r_left) + 17'(r_right);
        spd_diff = 17'(r_right) - 17'(r_left);
        cos_v    = r_neg ? -cord_x : cord_x;
        sin_v    = r_neg ? -cord_y : cord_y;
        // midpoint angle in 2^-24 turn: heading plus half the turn of this tick
        mid      = {r_heading, 8'b0} + r_prod[48:25];
        mid_neg  = ($signed(mid) > ddo_pkg::QUARTER_TURN) ||
                   ($signed(mid) < -ddo_pkg::QUARTER_TURN);
        d_rnd    = r_d + 25'd128;
        sum_x    = 34'(r_pos_x) + 34'($signed(r_prod[62:35]));
        sum_y    = 34'(r_pos_y) + 34'($signed(r_prod[62:35]));
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MV: begin
                mul_a = 34'(r_radius);
                mul_b = 34'(spd_sum);
            end
            S_MW1: begin
                mul_a = 34'(r_radius);
                mul_b = 34'(spd_diff);
            end
            S_MW2: begin
                mul_a = 34'($signed(r_prod[32:0]));
                mul_b = 34'(r_binv);
            end
            S_MP: begin
                mul_a = 34'($signed(r_prod[48:16]));
                mul_b = 34'(r_tick);
            end
            S_MD: begin
                mul_a = $signed(r_prod[49:16]);
                mul_b = ddo_pkg::INV_TWO_PI_Q32;
            end
            S_MA: begin
                mul_a = 34'(r_vfull);
                mul_b = 34'(r_tick);
            end
            S_MZ: begin
                mul_a = 34'($signed(r_a));
                mul_b = ddo_pkg::TWO_PI_Q30;
            end
            S_MX: begin
                mul_a = 34'(r_dist);
                mul_b = cos_v;
            end
            S_MY: begin
                mul_a = 34'(r_dist);
                mul_b = sin_v;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= ddo_pkg::RADIUS_RESET;
            r_binv   <= ddo_pkg::BINV_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ddo_pkg::REG_RADIUS: r_radius <= i_cfg_data;
                ddo_pkg::REG_BINV:   r_binv   <= i_cfg_data;
                default:             r_radius <= r_radius;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_heading   <= '0;
            r_left      <= '0;
            r_right     <= '0;
        end else begin
            // the final state refills the output register itself
            if (r_out_valid && m_axis_tready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_tick <= s_axis_tdata[47:32];
                        r_upd  <= (s_axis_tuser == ddo_pkg::CMD_TICK) &&
                                  (s_axis_tdata[47:32] != '0);
                        if (s_axis_tuser == ddo_pkg::CMD_CLEAR) begin
                            r_pos_x   <= '0;
                            r_pos_y   <= '0;
                            r_heading <= '0;
                        end else if (s_axis_tdata[47:32] != '0) begin
                            r_left  <= $signed(s_axis_tdata[15:0]);
                            r_right <= $signed(s_axis_tdata[31:16]);
                        end
                        r_state <= S_MV;
                    end
                end
                S_MV:  r_state <= S_MW1;
                S_MW1: begin
                    r_vfull <= $signed(r_prod[32:0]);
                    r_state <= S_MW2;
                end
                S_MW2: r_state <= S_MP;
                S_MP: begin
                    r_wrate <= $signed(r_prod[48:24]);
                    r_state <= r_upd ? S_MD : S_FIN;
                end
                S_MD: r_state <= S_MA;
                S_MA: begin
                    r_d     <= r_prod[48:24];
                    // fold into the right half plane, flipping the result sign
                    r_a     <= {mid[23] ^ mid_neg, mid[22:0]};
                    r_neg   <= mid_neg;
                    r_state <= S_MZ;
                end
                S_MZ: begin
                    r_dist  <= $signed(r_prod[49:20]);
                    r_state <= S_CST;
                end
                S_CST: r_state <= S_CORD;
                S_CORD: begin
                    if (cord_done) begin
                        r_state <= S_MX;
                    end
                end
                S_MX: r_state <= S_MY;
                S_MY: begin
                    r_pos_x <= ddo_pkg::sat_32(sum_x);
                    r_state <= S_MH;
                end
                S_MH: begin
                    r_pos_y   <= ddo_pkg::sat_32(sum_y);
                    r_heading <= r_heading + d_rnd[23:8];
                    r_state   <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {ddo_pkg::sat_16(r_wrate), r_vfull[32:17],
                                        r_heading, r_pos_y, r_pos_x};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_clear_pose: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_axis_tuser == ddo_pkg::CMD_CLEAR) |=>
            (r_pos_x == '0 && r_pos_y == '0 && r_heading == '0))
        else $error("clear command did not zero the pose");

    a_zero_tick_keeps_speeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_axis_tuser == ddo_pkg::CMD_TICK && s_axis_tdata[47:32] == '0) |=>
            (r_left == $past(r_left) && r_right == $past(r_right)))
        else $error("zero tick length changed the stored speeds");

    a_cordic_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cord_done |-> (r_state == S_CORD))
        else $error("cordic finished outside its wait state");

endmodule
